[rtl/core/stepper_trapezoid_ramp_driver_assert.svh]
// Assertion macros used by the top-level RTL in this folder.
`ifndef STEPPER_TRAPEZOID_RAMP_DRIVER_ASSERT_SVH
`define STEPPER_TRAPEZOID_RAMP_DRIVER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define STRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define STRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/strd_pkg.sv]
package strd_pkg;

    localparam int RAMP_W     = 14;
    localparam int MINP_W     = 15;
    localparam int CFG_DATA_W = 15;
    localparam int REQ_W      = 3;
    localparam int FIELD_W    = 32;

    localparam logic [RAMP_W-1:0] RAMP_RESET = 14'd1024;
    localparam logic [MINP_W-1:0] MINP_RESET = 15'd256;

    localparam logic REG_RAMP_STEPS = 1'b0;
    localparam logic REG_MIN_PERIOD = 1'b1;

    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TARGET  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ZERO    = 3'd4;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_DISABLE = 2'd1,
        CMD_ENABLE  = 2'd2,
        CMD_ZERO    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_UP     = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DOWN   = 2'd2
    } phase_t;

    typedef struct packed {
        logic   moving;
        logic   dir;
        phase_t phase;
    } ctl_t;

endpackage

[rtl/core/strd_plan.sv]
module strd_plan #(
    parameter int POS_WIDTH    = 32,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic [POS_WIDTH-1:0]           cur_pos,
    input  logic [POS_WIDTH-1:0]           tgt_pos,
    input  logic [strd_pkg::RAMP_W-1:0]    ramp_steps,
    input  logic [strd_pkg::MINP_W-1:0]    min_period,
    output logic                           differ,
    output strd_pkg::ctl_t                 ctl,
    output logic [POS_WIDTH-1:0]           left,
    output logic [POS_WIDTH-1:0]           cruise,
    output logic [POS_WIDTH-1:0]           down,
    output logic [PERIOD_WIDTH-1:0]        period
);

    localparam int CW = (POS_WIDTH > strd_pkg::RAMP_W + 1) ? POS_WIDTH : strd_pkg::RAMP_W + 1;
    localparam int SW = (PERIOD_WIDTH > 16) ? PERIOD_WIDTH : 16;
    localparam int unsigned PMAX_I = (1 << PERIOD_WIDTH) - 1;

    logic                 dir;
    logic [POS_WIDTH-1:0] span;
    logic [POS_WIDTH-1:0] half_down;
    logic [POS_WIDTH-1:0] half_up;
    logic [CW-1:0]        span_ext;
    logic [CW-1:0]        ramp2;
    logic [CW-1:0]        ramp_ext;
    logic [CW-1:0]        rest;
    logic                 full;
    logic [SW-1:0]        sum;

    assign differ    = cur_pos != tgt_pos;
    assign dir       = $signed(cur_pos) > $signed(tgt_pos);
    assign span      = dir ? (cur_pos - tgt_pos) : (tgt_pos - cur_pos);
    assign half_down = span >> 1;
    assign half_up   = span - half_down;
    assign span_ext  = CW'(span);
    assign ramp2     = CW'({ramp_steps, 1'b0});
    assign ramp_ext  = CW'(ramp_steps);
    assign rest      = span_ext - ramp2;
    assign full      = span_ext >= ramp2;
    assign sum       = SW'(ramp_steps) + SW'(min_period);

    always_comb
    begin
        ctl.moving = 1'b1;
        ctl.dir    = dir;
        if (full)
        begin
            cruise = rest[POS_WIDTH-1:0];
            down   = ramp_ext[POS_WIDTH-1:0];
        end
        else
        begin
            cruise = '0;
            down   = half_down;
        end
        // skip an empty ramp straight into cruise
        if (ramp_steps == '0)
        begin
            ctl.phase = strd_pkg::PH_CRUISE;
            left      = span;
        end
        else
        begin
            ctl.phase = strd_pkg::PH_UP;
            left      = full ? ramp_ext[POS_WIDTH-1:0] : half_up;
        end
        if (sum > SW'(PMAX_I))
            period = PERIOD_WIDTH'(PMAX_I);
        else
            period = sum[PERIOD_WIDTH-1:0];
    end

endmodule

[rtl/core/strd_tick.sv]
module strd_tick #(
    parameter int POS_WIDTH    = 32,
    parameter int PERIOD_WIDTH = 16
) (
    input  strd_pkg::ctl_t          ctl_in,
    input  logic [POS_WIDTH-1:0]    left_in,
    input  logic [POS_WIDTH-1:0]    cruise,
    input  logic [POS_WIDTH-1:0]    down,
    input  logic [PERIOD_WIDTH-1:0] period_in,
    input  logic [PERIOD_WIDTH-1:0] tick_in,
    input  logic [POS_WIDTH-1:0]    pos_in,
    output strd_pkg::ctl_t          ctl_out,
    output logic [POS_WIDTH-1:0]    left_out,
    output logic [PERIOD_WIDTH-1:0] period_out,
    output logic [PERIOD_WIDTH-1:0] tick_out,
    output logic [POS_WIDTH-1:0]    pos_out
);

    localparam logic [PERIOD_WIDTH-1:0] PMAX = {PERIOD_WIDTH{1'b1}};

    logic [POS_WIDTH-1:0] left_dec;

    assign left_dec = left_in - POS_WIDTH'(1);

    always_comb
    begin
        ctl_out    = ctl_in;
        left_out   = left_in;
        period_out = period_in;
        tick_out   = tick_in;
        pos_out    = pos_in;
        if (ctl_in.moving)
        begin
            if (tick_in < period_in)
                tick_out = tick_in + PERIOD_WIDTH'(1);
            else
            begin
                tick_out = '0;
                pos_out  = ctl_in.dir ? (pos_in - POS_WIDTH'(1)) : (pos_in + POS_WIDTH'(1));
                case (ctl_in.phase)
                    strd_pkg::PH_UP:
                    begin
                        if (period_in != '0)
                            period_out = period_in - PERIOD_WIDTH'(1);
                    end
                    strd_pkg::PH_DOWN:
                    begin
                        if (period_in != PMAX)
                            period_out = period_in + PERIOD_WIDTH'(1);
                    end
                    default:
                    begin
                    end
                endcase
                left_out = left_dec;
                // advance past phases with no steps
                if (left_dec == '0)
                begin
                    case (ctl_in.phase)
                        strd_pkg::PH_UP:
                        begin
                            if (cruise != '0)
                            begin
                                ctl_out.phase = strd_pkg::PH_CRUISE;
                                left_out      = cruise;
                            end
                            else if (down != '0)
                            begin
                                ctl_out.phase = strd_pkg::PH_DOWN;
                                left_out      = down;
                            end
                            else
                            begin
                                ctl_out.moving = 1'b0;
                                ctl_out.phase  = strd_pkg::PH_UP;
                            end
                        end
                        strd_pkg::PH_CRUISE:
                        begin
                            if (down != '0)
                            begin
                                ctl_out.phase = strd_pkg::PH_DOWN;
                                left_out      = down;
                            end
                            else
                            begin
                                ctl_out.moving = 1'b0;
                                ctl_out.phase  = strd_pkg::PH_UP;
                            end
                        end
                        default:
                        begin
                            ctl_out.moving = 1'b0;
                            ctl_out.phase  = strd_pkg::PH_UP;
                        end
                    endcase
                end
            end
        end
    end

endmodule

[rtl/core/stepper_trapezoid_ramp_driver.sv]
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   req_type, target_value
// result    out        out_valid / out_stall step_pin, dir_pin, enable_pin, busy_res,
//                                            position, target_position
// config    in         cfg_we                cfg_index, cfg_data
//
// One result per input, registered, ready the next cycle.
// The motion update (start planning, then tick counting) is one combinational pass.
// A new input is taken every cycle while the result register is empty or being drained.
// in_stall rises only while a result is held by out_stall.
// rst_n clears the control state asynchronously (not the result payload); config registers return to 1024 and 256.
`include "stepper_trapezoid_ramp_driver_assert.svh"

module stepper_trapezoid_ramp_driver #(
    parameter int POS_WIDTH    = 32,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [strd_pkg::REQ_W-1:0]          req_type,
    input  logic signed [strd_pkg::FIELD_W-1:0] target_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                step_pin,
    output logic                                dir_pin,
    output logic                                enable_pin,
    output logic                                busy_res,
    output logic signed [strd_pkg::FIELD_W-1:0] position,
    output logic signed [strd_pkg::FIELD_W-1:0] target_position,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [strd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [strd_pkg::RAMP_W-1:0] ramp_reg;
    logic [strd_pkg::MINP_W-1:0] minp_reg;

    strd_pkg::ctl_t          ctl_reg,    ctl_next,    ctl_a,    ctl_t_out, plan_ctl;
    strd_pkg::cmd_t          pend_reg,   pend_next,   pend_a;
    logic [POS_WIDTH-1:0]    pos_reg,    pos_next,    pos_a,    pos_t_out;
    logic [POS_WIDTH-1:0]    tgt_reg,    tgt_next,    tgt_a;
    logic [POS_WIDTH-1:0]    left_reg,   left_next,   left_a,   left_t_out, plan_left;
    logic [POS_WIDTH-1:0]    cruise_reg, cruise_next, cruise_a, plan_cruise;
    logic [POS_WIDTH-1:0]    down_reg,   down_next,   down_a,   plan_down;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next, period_a, period_t_out, plan_period;
    logic [PERIOD_WIDTH-1:0] tick_reg,   tick_next,   tick_a,   tick_t_out;
    logic                    off_reg,    off_next,    off_a;
    logic                    plan_differ;

    logic out_valid_reg, out_valid_next;
    logic step_pin_reg, dir_pin_reg, enable_pin_reg, busy_res_reg;
    logic signed [strd_pkg::FIELD_W-1:0] position_reg, target_position_reg;

    logic accept;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    strd_plan #(
        .POS_WIDTH    (POS_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_plan (
        .cur_pos    (pos_reg),
        .tgt_pos    (tgt_reg),
        .ramp_steps (ramp_reg),
        .min_period (minp_reg),
        .differ     (plan_differ),
        .ctl        (plan_ctl),
        .left       (plan_left),
        .cruise     (plan_cruise),
        .down       (plan_down),
        .period     (plan_period)
    );

    // apply pending command and start a move while idle
    always_comb
    begin
        ctl_a    = ctl_reg;
        pend_a   = pend_reg;
        pos_a    = pos_reg;
        tgt_a    = tgt_reg;
        left_a   = left_reg;
        cruise_a = cruise_reg;
        down_a   = down_reg;
        period_a = period_reg;
        tick_a   = tick_reg;
        off_a    = off_reg;
        if (!ctl_reg.moving)
        begin
            unique case (pend_reg)
                strd_pkg::CMD_DISABLE: off_a = 1'b1;
                strd_pkg::CMD_ENABLE:  off_a = 1'b0;
                strd_pkg::CMD_ZERO:
                begin
                    pos_a = '0;
                    tgt_a = '0;
                end
                default:
                begin
                end
            endcase
            pend_a = strd_pkg::CMD_NONE;
            if (pend_reg != strd_pkg::CMD_ZERO && plan_differ)
            begin
                ctl_a    = plan_ctl;
                left_a   = plan_left;
                cruise_a = plan_cruise;
                down_a   = plan_down;
                period_a = plan_period;
                tick_a   = '0;
            end
        end
    end

    strd_tick #(
        .POS_WIDTH    (POS_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_tick (
        .ctl_in     (ctl_a),
        .left_in    (left_a),
        .cruise     (cruise_a),
        .down       (down_a),
        .period_in  (period_a),
        .tick_in    (tick_a),
        .pos_in     (pos_a),
        .ctl_out    (ctl_t_out),
        .left_out   (left_t_out),
        .period_out (period_t_out),
        .tick_out   (tick_t_out),
        .pos_out    (pos_t_out)
    );

    always_comb
    begin
        ctl_next    = ctl_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        left_next   = left_reg;
        cruise_next = cruise_reg;
        down_next   = down_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        off_next    = off_reg;
        if (accept)
        begin
            unique case (req_type)
                strd_pkg::REQ_TICK:
                begin
                    ctl_next    = ctl_t_out;
                    pend_next   = pend_a;
                    pos_next    = pos_t_out;
                    tgt_next    = tgt_a;
                    left_next   = left_t_out;
                    cruise_next = cruise_a;
                    down_next   = down_a;
                    period_next = period_t_out;
                    tick_next   = tick_t_out;
                    off_next    = off_a;
                end
                strd_pkg::REQ_TARGET:  tgt_next  = target_value[POS_WIDTH-1:0];
                strd_pkg::REQ_DISABLE: pend_next = strd_pkg::CMD_DISABLE;
                strd_pkg::REQ_ENABLE:  pend_next = strd_pkg::CMD_ENABLE;
                strd_pkg::REQ_ZERO:    pend_next = strd_pkg::CMD_ZERO;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg      <= strd_pkg::RAMP_RESET;
            minp_reg      <= strd_pkg::MINP_RESET;
            ctl_reg       <= '{moving: 1'b0, dir: 1'b0, phase: strd_pkg::PH_UP};
            pend_reg      <= strd_pkg::CMD_NONE;
            pos_reg       <= '0;
            tgt_reg       <= '0;
            left_reg      <= '0;
            cruise_reg    <= '0;
            down_reg      <= '0;
            period_reg    <= '0;
            tick_reg      <= '0;
            off_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    strd_pkg::REG_RAMP_STEPS: ramp_reg <= cfg_data[strd_pkg::RAMP_W-1:0];
                    strd_pkg::REG_MIN_PERIOD: minp_reg <= cfg_data[strd_pkg::MINP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            ctl_reg       <= ctl_next;
            pend_reg      <= pend_next;
            pos_reg       <= pos_next;
            tgt_reg       <= tgt_next;
            left_reg      <= left_next;
            cruise_reg    <= cruise_next;
            down_reg      <= down_next;
            period_reg    <= period_next;
            tick_reg      <= tick_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the result of each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_pin_reg        <= ctl_next.moving && (tick_next != '0);
            dir_pin_reg         <= ctl_next.dir;
            enable_pin_reg      <= off_next;
            busy_res_reg        <= ctl_next.moving;
            position_reg        <= strd_pkg::FIELD_W'($signed(pos_next));
            target_position_reg <= strd_pkg::FIELD_W'($signed(tgt_next));
        end
    end

    assign out_valid       = out_valid_reg;
    assign step_pin        = step_pin_reg;
    assign dir_pin         = dir_pin_reg;
    assign enable_pin      = enable_pin_reg;
    assign busy_res        = busy_res_reg;
    assign position        = position_reg;
    assign target_position = target_position_reg;

    `STRD_ASSERT_SAME(a_idle_phase_up, !ctl_reg.moving, ctl_reg.phase == strd_pkg::PH_UP, "idle with phase not ramp up")
    `STRD_ASSERT_SAME(a_moving_has_steps, ctl_reg.moving, left_reg != '0, "moving with no steps left")
    `STRD_ASSERT_SAME(a_tick_in_range, ctl_reg.moving, tick_reg <= period_reg, "tick count past period")
    `STRD_ASSERT_NEXT(a_nontick_keeps_pos, accept && (req_type != strd_pkg::REQ_TICK), $stable(pos_reg), "position changed on non-tick transaction")

endmodule

[sim/ramp_checker.sv]
module ramp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [strd_pkg::REQ_W-1:0]          req_type,
    input  logic signed [strd_pkg::FIELD_W-1:0] target_value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                step_pin,
    input  logic                                dir_pin,
    input  logic                                enable_pin,
    input  logic                                busy_res,
    input  logic signed [strd_pkg::FIELD_W-1:0] position,
    input  logic signed [strd_pkg::FIELD_W-1:0] target_position,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [strd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  waiting,
    output int                                  errors
);

    typedef struct packed {
        logic        step;
        logic        dir;
        logic        off;
        logic        busy;
        logic [31:0] pos;
        logic [31:0] tgt;
    } pins_t;

    pins_t       pin_levels[$];

    logic [31:0]       pos_q;
    logic [31:0]       tgt_q;
    logic [31:0]       steps_left;
    logic [31:0]       cruise_len;
    logic [31:0]       down_len;
    strd_pkg::cmd_t    held_cmd;
    logic              moving;
    logic              dir_q;
    logic              drv_off;
    strd_pkg::phase_t  ph;
    logic [15:0]       period;
    logic [15:0]       ticks;
    logic [13:0]       ramp_cfg;
    logic [14:0]       minp_cfg;

    task automatic report(input string what);
        $display("%0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    task automatic skip_empty_phases();
        while (moving && steps_left == 0)
        begin
            case (ph)
                strd_pkg::PH_UP:
                begin
                    ph = strd_pkg::PH_CRUISE;
                    steps_left = cruise_len;
                end
                strd_pkg::PH_CRUISE:
                begin
                    ph = strd_pkg::PH_DOWN;
                    steps_left = down_len;
                end
                default:
                begin
                    moving = 1'b0;
                    ph = strd_pkg::PH_UP;
                end
            endcase
        end
    endtask

    task automatic plan_move();
        logic [31:0] c;
        logic [31:0] t;
        logic [31:0] span;
        logic [31:0] full_ramp;
        logic [16:0] sum;
        c = pos_q ^ 32'h8000_0000;
        t = tgt_q ^ 32'h8000_0000;
        dir_q = c > t;
        span = dir_q ? c - t : t - c;
        full_ramp = {17'd0, ramp_cfg, 1'b0};
        if (span >= full_ramp)
        begin
            steps_left = {18'd0, ramp_cfg};
            down_len = {18'd0, ramp_cfg};
            cruise_len = span - full_ramp;
        end
        else
        begin
            down_len = span >> 1;
            steps_left = span - down_len;
            cruise_len = 32'd0;
        end
        sum = {3'd0, ramp_cfg} + {2'd0, minp_cfg};
        period = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
        ticks = 16'd0;
        ph = strd_pkg::PH_UP;
        moving = 1'b1;
        skip_empty_phases();
    endtask

    task automatic step_tick();
        if (ticks < period)
        begin
            ticks++;
            return;
        end
        ticks = 16'd0;
        pos_q = dir_q ? pos_q - 32'd1 : pos_q + 32'd1;
        if (ph == strd_pkg::PH_UP)
        begin
            if (period > 16'd0)
                period--;
        end
        else if (ph == strd_pkg::PH_DOWN)
        begin
            if (period < 16'hFFFF)
                period++;
        end
        steps_left--;
        skip_empty_phases();
    endtask

    task automatic apply_request(input logic [strd_pkg::REQ_W-1:0] kind,
                                 input logic [31:0] val);
        pins_t p;
        case (kind)
            strd_pkg::REQ_TICK:
            begin
                if (!moving)
                begin
                    case (held_cmd)
                        strd_pkg::CMD_DISABLE: drv_off = 1'b1;
                        strd_pkg::CMD_ENABLE:  drv_off = 1'b0;
                        strd_pkg::CMD_ZERO:
                        begin
                            pos_q = 32'd0;
                            tgt_q = 32'd0;
                        end
                        default: ;
                    endcase
                    held_cmd = strd_pkg::CMD_NONE;
                    if (pos_q != tgt_q)
                        plan_move();
                end
                if (moving)
                    step_tick();
            end
            strd_pkg::REQ_TARGET:  tgt_q = val;
            strd_pkg::REQ_DISABLE: held_cmd = strd_pkg::CMD_DISABLE;
            strd_pkg::REQ_ENABLE:  held_cmd = strd_pkg::CMD_ENABLE;
            strd_pkg::REQ_ZERO:    held_cmd = strd_pkg::CMD_ZERO;
            default: ;
        endcase
        p.step = moving && ticks != 16'd0;
        p.dir = dir_q;
        p.off = drv_off;
        p.busy = moving;
        p.pos = pos_q;
        p.tgt = tgt_q;
        pin_levels.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pins_t want;
        if (!rst_n)
        begin
            pin_levels.delete();
            pos_q = 32'd0;
            tgt_q = 32'd0;
            steps_left = 32'd0;
            cruise_len = 32'd0;
            down_len = 32'd0;
            held_cmd = strd_pkg::CMD_NONE;
            moving = 1'b0;
            dir_q = 1'b0;
            drv_off = 1'b0;
            ph = strd_pkg::PH_UP;
            period = 16'd0;
            ticks = 16'd0;
            ramp_cfg = strd_pkg::RAMP_RESET;
            minp_cfg = strd_pkg::MINP_RESET;
            waiting = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == strd_pkg::REG_RAMP_STEPS)
                    ramp_cfg = cfg_data[strd_pkg::RAMP_W-1:0];
                else
                    minp_cfg = cfg_data[strd_pkg::MINP_W-1:0];
            end
            if (in_valid && !in_stall)
                apply_request(req_type, target_value);
            if (out_valid && !out_stall)
            begin
                if (pin_levels.size() == 0)
                    report("result transaction with nothing pending");
                else
                begin
                    want = pin_levels.pop_front();
                    compare_field("step_pin", {31'd0, step_pin}, {31'd0, want.step});
                    compare_field("dir_pin", {31'd0, dir_pin}, {31'd0, want.dir});
                    compare_field("enable_pin", {31'd0, enable_pin}, {31'd0, want.off});
                    compare_field("busy_res", {31'd0, busy_res}, {31'd0, want.busy});
                    compare_field("position", position, want.pos);
                    compare_field("target_position", target_position, want.tgt);
                end
            end
            waiting = pin_levels.size();
        end
    end

endmodule

[sim/tb.sv]
module tb;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [strd_pkg::REQ_W-1:0]          req_type;
    logic signed [strd_pkg::FIELD_W-1:0] target_value;
    logic                                out_valid;
    logic                                out_stall;
    logic                                step_pin;
    logic                                dir_pin;
    logic                                enable_pin;
    logic                                busy_res;
    logic signed [strd_pkg::FIELD_W-1:0] position;
    logic signed [strd_pkg::FIELD_W-1:0] target_position;
    logic                                cfg_we;
    logic                                cfg_index;
    logic [strd_pkg::CFG_DATA_W-1:0]     cfg_data;
    int                                  waiting;
    int                                  errors;

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit held = 1'b0;

    stepper_trapezoid_ramp_driver dut (.*);

    ramp_checker chk (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("stepper_trapezoid_ramp_driver: mismatch");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic push(input logic [strd_pkg::REQ_W-1:0] kind, input logic [31:0] val);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        target_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    task automatic reprogram(input logic [strd_pkg::RAMP_W-1:0] ramp,
                             input logic [strd_pkg::MINP_W-1:0] minp);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= strd_pkg::REG_RAMP_STEPS;
        cfg_data <= {1'b0, ramp};
        @(posedge clk);
        cfg_index <= strd_pkg::REG_MIN_PERIOD;
        cfg_data <= minp;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic near_target();
        int off;
        off = $urandom_range(0, 16);
        push(strd_pkg::REQ_TARGET, off - 8);
    endtask

    task automatic random_traffic(input int count);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                push(strd_pkg::REQ_TICK, $urandom());
            else if (roll < 78)
                near_target();
            else if (roll < 81)
            begin
                push(strd_pkg::REQ_TARGET, $urandom());
                near_target();
            end
            else if (roll < 84)
                push(strd_pkg::REQ_DISABLE, $urandom());
            else if (roll < 87)
                push(strd_pkg::REQ_ENABLE, $urandom());
            else if (roll < 90)
                push(strd_pkg::REQ_ZERO, $urandom());
            else if (roll < 92)
                push(strd_pkg::REQ_ZERO + 3'($urandom_range(1, 3)), $urandom());
            else
                repeat ($urandom_range(5, 20))
                    push(strd_pkg::REQ_TICK, $urandom());
            if (count == 50 && i == 25 && !hold_req)
                hold_req = 1'b1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = strd_pkg::REQ_TICK;
        target_value = '0;
        cfg_we = 1'b0;
        cfg_index = strd_pkg::REG_RAMP_STEPS;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push(strd_pkg::REQ_TICK, 32'd0);
        push(strd_pkg::REQ_DISABLE, 32'd0);
        push(strd_pkg::REQ_TICK, 32'd0);
        push(strd_pkg::REQ_ENABLE, 32'd0);

        reprogram(14'd1, 15'd1);
        push(strd_pkg::REQ_TARGET, 32'h7FFF_FFFF);
        push(strd_pkg::REQ_TARGET, 32'h8000_0000);
        push(strd_pkg::REQ_TARGET, 32'd5);
        push(strd_pkg::REQ_ZERO + 3'd1, 32'hFFFF_FFFF);
        push(strd_pkg::REQ_ZERO + 3'd2, 32'h0000_0000);
        push(strd_pkg::REQ_ZERO + 3'd3, 32'hAAAA_5555);
        push(strd_pkg::REQ_TICK, 32'd0);
        push(strd_pkg::REQ_TARGET, -32'sd3);
        push(strd_pkg::REQ_DISABLE, 32'd0);
        push(strd_pkg::REQ_ZERO, 32'd0);
        push(strd_pkg::REQ_TARGET, 32'd2);
        repeat (14)
            push(strd_pkg::REQ_TICK, 32'd0);

        reprogram(14'd0, 15'd1);
        random_traffic(50);
        reprogram(14'd3, 15'd2);
        random_traffic(50);
        reprogram(14'd1, 15'd3);
        random_traffic(50);
        reprogram(14'($urandom_range(0, 4)), 15'($urandom_range(1, 4)));
        random_traffic(50);
        reprogram(14'd2, 15'd1);
        random_traffic(49);

        reprogram(14'h3FFF, 15'h7FFF);
        quiet = 1'b1;
        random_traffic(20);

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("stepper_trapezoid_ramp_driver: match");
        else
            $display("stepper_trapezoid_ramp_driver: mismatch");
        $finish;
    end

endmodule
